>>> hw/rtl/kmpq_pkg.sv
package kmpq_pkg;

  // sizes of the queue
  localparam int CAPACITY = 1024;
  localparam int KEY_BITS = 20;
  localparam int PRIO_W   = 63;
  localparam int IN_KEY_W = 20;
  localparam int OCC_W    = 11;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // cells are grouped for the registered prefix tree
  localparam int GRP  = 32;
  localparam int NGRP = (CAPACITY + GRP - 1) / GRP;
  localparam int NPAD = NGRP * GRP;

  // operation codes of the input transaction
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_POP    = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // command broadcast to every cell of the chain
  typedef enum logic [2:0] {
    OP_NONE,
    OP_MATCH,
    OP_PREFIX,
    OP_REMOVE,
    OP_POP,
    OP_PLACE
  } op_e;

  typedef struct packed {
    logic                valid;
    logic [KEY_BITS-1:0] key;
    logic [PRIO_W-1:0]   prio;
  } entry_t;

  typedef struct packed {
    op_e                 op;
    logic [KEY_BITS-1:0] key;
    logic [PRIO_W-1:0]   prio;
  } cmd_t;

endpackage

>>> hw/rtl/kmpq_cell.sv
module kmpq_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  kmpq_pkg::cmd_t    cmd_i,
  input  kmpq_pkg::entry_t  left_i,
  input  logic              left_le_i,
  input  kmpq_pkg::entry_t  right_i,
  input  logic              pre_in_i,
  input  logic              grp_pre_i,
  output kmpq_pkg::entry_t  entry_o,
  output logic              le_o,
  output logic              match_o
);

  logic                          valid_q, valid_d;
  logic [kmpq_pkg::KEY_BITS-1:0] key_q, key_d;
  logic [kmpq_pkg::PRIO_W-1:0]   prio_q, prio_d;
  logic                          match_q, match_d;
  logic                          pre_q, pre_d;

  assign entry_o = '{valid: valid_q, key: key_q, prio: prio_q};
  assign match_o = match_q;

  // held entry sorts at or before the broadcast priority
  assign le_o = valid_q && (prio_q <= cmd_i.prio);

  // next content of the cell
  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    prio_d  = prio_q;
    match_d = match_q;
    pre_d   = pre_q;
    case (cmd_i.op)
      kmpq_pkg::OP_MATCH: begin
        match_d = valid_q && (key_q == cmd_i.key);
      end
      kmpq_pkg::OP_PREFIX: begin
        pre_d = pre_in_i;
      end
      kmpq_pkg::OP_REMOVE: begin
        // cells at and after the matched one pull from the right
        if (pre_q || grp_pre_i) begin
          valid_d = right_i.valid;
          key_d   = right_i.key;
          prio_d  = right_i.prio;
        end
      end
      kmpq_pkg::OP_POP: begin
        valid_d = right_i.valid;
        key_d   = right_i.key;
        prio_d  = right_i.prio;
      end
      kmpq_pkg::OP_PLACE: begin
        // first cell past the insertion point takes the new entry, the rest shift right
        if (!le_o) begin
          if (left_le_i) begin
            valid_d = 1'b1;
            key_d   = cmd_i.key;
            prio_d  = cmd_i.prio;
          end else begin
            valid_d = left_i.valid;
            key_d   = left_i.key;
            prio_d  = left_i.prio;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // control bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
      pre_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      match_q <= match_d;
      pre_q   <= pre_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    prio_q <= prio_d;
  end

endmodule

>>> hw/rtl/kmpq_chain.sv
module kmpq_chain (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  kmpq_pkg::cmd_t    cmd_i,
  output kmpq_pkg::entry_t  head_o,
  output logic              any_o
);

  localparam int Cap  = kmpq_pkg::CAPACITY;
  localparam int Grp  = kmpq_pkg::GRP;
  localparam int NGrp = kmpq_pkg::NGRP;
  localparam int NPad = kmpq_pkg::NPAD;

  kmpq_pkg::entry_t ent [Cap];
  logic [Cap-1:0]   le;
  logic [Cap-1:0]   match;
  logic [NPad-1:0]  match_pad;
  logic [Cap-1:0]   pre_in;
  logic [NGrp-1:0]  grp_any;
  logic [NGrp-1:0]  grp_pre_d, grp_pre_q;

  // pad the match vector up to whole groups
  generate
    if (NPad > Cap) begin : g_pad
      assign match_pad = {{(NPad - Cap){1'b0}}, match};
    end else begin : g_nopad
      assign match_pad = match;
    end
  endgenerate

  // per-group match summary and exclusive prefix over groups
  generate
    for (genvar g = 0; g < NGrp; g++) begin : g_grp
      localparam logic [NGrp-1:0] GMask = {NGrp{1'b1}} >> (NGrp - g);
      assign grp_any[g]   = |match_pad[g*Grp +: Grp];
      assign grp_pre_d[g] = |(grp_any & GMask);
    end
  endgenerate

  assign any_o = |grp_any;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_pre_q <= '0;
    end else begin
      grp_pre_q <= grp_pre_d;
    end
  end

  // row of cells
  generate
    for (genvar i = 0; i < Cap; i++) begin : g_cell
      localparam int G = i / Grp;
      localparam int O = i % Grp;
      localparam logic [Grp-1:0] LMask = {Grp{1'b1}} >> (Grp - 1 - O);

      kmpq_pkg::entry_t left, right;
      logic             left_le;

      // in-group inclusive prefix of the match bits
      assign pre_in[i] = |(match_pad[G*Grp +: Grp] & LMask);

      if (i == 0) begin : g_first
        assign left    = '0;
        assign left_le = 1'b1;
      end else begin : g_inner
        assign left    = ent[i-1];
        assign left_le = le[i-1];
      end

      if (i == Cap - 1) begin : g_last
        assign right = '0;
      end else begin : g_notlast
        assign right = ent[i+1];
      end

      kmpq_cell u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .cmd_i     (cmd_i),
        .left_i    (left),
        .left_le_i (left_le),
        .right_i   (right),
        .pre_in_i  (pre_in[i]),
        .grp_pre_i (grp_pre_q[G]),
        .entry_o   (ent[i]),
        .le_o      (le[i]),
        .match_o   (match[i])
      );
    end
  endgenerate

  assign head_o = ent[0];

endmodule

>>> hw/rtl/keyed_min_priority_queue_unit.sv
// Keyed min-priority queue held as a sorted row of cells, smallest priority
// at the head, equal priorities in order of placement.
// Input channel: in_valid_i / in_stall_o with func_i, item_key_i and
// item_priority_i. func_i selects insert-or-update or pop.
// Output channel: out_valid_o / out_stall_i, one result transaction per
// input transaction, in order: status, was_present, popped key and
// priority, and occupancy after the operation.
// One operation is worked at a time; the command steps through match,
// group prefix, decide, remove and place phases of the cell row, as the
// operation needs them. The next transaction is accepted in the cycle
// after the result is loaded.
// A finished result sits in the output register; new input is accepted
// while it waits. If the receiver still stalls when the next result is
// ready, the block holds that result and stalls its input.
// Reset empties the queue (all cells invalid, occupancy zero) and clears the
// output valid flag; the output payload is not reset.
module keyed_min_priority_queue_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            func_i,
  input  logic [kmpq_pkg::IN_KEY_W-1:0]   item_key_i,
  input  logic [kmpq_pkg::PRIO_W-1:0]     item_priority_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [kmpq_pkg::STATUS_W-1:0]   status_o,
  output logic                            was_present_o,
  output logic [kmpq_pkg::IN_KEY_W-1:0]   out_key_o,
  output logic [kmpq_pkg::PRIO_W-1:0]     out_priority_o,
  output logic [kmpq_pkg::OCC_W-1:0]      occupancy_o
);

  localparam int KeyBits = kmpq_pkg::KEY_BITS;
  localparam int InKeyW  = kmpq_pkg::IN_KEY_W;
  localparam int CntW    = kmpq_pkg::CNT_W;
  localparam int OccW    = kmpq_pkg::OCC_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MATCH  = 3'd1;
  localparam logic [2:0] S_GROUP  = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_REMOVE = 3'd4;
  localparam logic [2:0] S_PLACE  = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  localparam logic [CntW-1:0] CapCnt = CntW'(kmpq_pkg::CAPACITY);

  logic [2:0]                      state_q, state_d;
  logic [CntW-1:0]                 count_q, count_d;
  logic                            op_pop_q, op_pop_d;
  logic [KeyBits-1:0]              op_key_q, op_key_d;
  logic [kmpq_pkg::PRIO_W-1:0]     op_prio_q, op_prio_d;
  logic [kmpq_pkg::STATUS_W-1:0]   res_status_q, res_status_d;
  logic                            res_present_q, res_present_d;
  logic [KeyBits-1:0]              res_key_q, res_key_d;
  logic [kmpq_pkg::PRIO_W-1:0]     res_prio_q, res_prio_d;
  logic                            out_valid_q;
  logic [kmpq_pkg::STATUS_W-1:0]   out_status_q;
  logic                            out_present_q;
  logic [InKeyW-1:0]               out_key_q;
  logic [kmpq_pkg::PRIO_W-1:0]     out_prio_q;
  logic [OccW-1:0]                 out_occ_q;

  logic                            in_fire;
  logic                            out_free;
  logic                            load_out;
  kmpq_pkg::cmd_t                  cmd;
  kmpq_pkg::entry_t                head;
  logic                            any_match;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign load_out   = (state_q == S_DONE) && out_free;

  // command to the cell row for the current phase
  always_comb begin
    cmd.key  = op_key_q;
    cmd.prio = op_prio_q;
    case (state_q)
      S_MATCH:  cmd.op = kmpq_pkg::OP_MATCH;
      S_GROUP:  cmd.op = kmpq_pkg::OP_PREFIX;
      S_REMOVE: cmd.op = op_pop_q ? kmpq_pkg::OP_POP : kmpq_pkg::OP_REMOVE;
      S_PLACE:  cmd.op = kmpq_pkg::OP_PLACE;
      default:  cmd.op = kmpq_pkg::OP_NONE;
    endcase
  end

  kmpq_chain u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .head_o (head),
    .any_o  (any_match)
  );

  // operation sequencer
  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    op_pop_d      = op_pop_q;
    op_key_d      = op_key_q;
    op_prio_d     = op_prio_q;
    res_status_d  = res_status_q;
    res_present_d = res_present_q;
    res_key_d     = res_key_q;
    res_prio_d    = res_prio_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          op_pop_d      = (func_i == kmpq_pkg::FUNC_POP);
          op_key_d      = KeyBits'(item_key_i);
          op_prio_d     = item_priority_i;
          res_status_d  = kmpq_pkg::ST_OK;
          res_present_d = 1'b0;
          res_key_d     = '0;
          res_prio_d    = '0;
          if (func_i == kmpq_pkg::FUNC_POP) begin
            if (count_q == '0) begin
              res_status_d = kmpq_pkg::ST_EMPTY;
              state_d      = S_DONE;
            end else begin
              res_key_d  = head.key;
              res_prio_d = head.prio;
              state_d    = S_REMOVE;
            end
          end else begin
            state_d = S_MATCH;
          end
        end
      end
      S_MATCH: begin
        state_d = S_GROUP;
      end
      S_GROUP: begin
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (any_match) begin
          res_present_d = 1'b1;
          state_d       = S_REMOVE;
        end else if (count_q == CapCnt) begin
          res_status_d = kmpq_pkg::ST_FULL;
          state_d      = S_DONE;
        end else begin
          state_d = S_PLACE;
        end
      end
      S_REMOVE: begin
        count_d = count_q - 1'b1;
        state_d = op_pop_q ? S_DONE : S_PLACE;
      end
      S_PLACE: begin
        count_d = count_q + 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // operation and result payload
  always_ff @(posedge clk_i) begin
    op_pop_q      <= op_pop_d;
    op_key_q      <= op_key_d;
    op_prio_q     <= op_prio_d;
    res_status_q  <= res_status_d;
    res_present_q <= res_present_d;
    res_key_q     <= res_key_d;
    res_prio_q    <= res_prio_d;
  end

  // output register, loaded when the previous transaction is gone
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_status_q  <= res_status_q;
      out_present_q <= res_present_q;
      out_key_q     <= InKeyW'(res_key_q);
      out_prio_q    <= res_prio_q;
      out_occ_q     <= OccW'(count_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign was_present_o  = out_present_q;
  assign out_key_o      = out_key_q;
  assign out_priority_o = out_prio_q;
  assign occupancy_o    = out_occ_q;

endmodule
